@@ hw/rtl/pmqm_pkg.sv @@
// Shared types and constants for the priority mailbox queue manager.
// No dependencies.
`default_nettype none
package pmqm_pkg;
	localparam int MAX_BOXES     = 16;
	localparam int MAX_MESSAGES  = 64;
	localparam int PAYLOAD_BYTES = 8;
	localparam int BOX_W  = $clog2(MAX_BOXES) > 0 ? $clog2(MAX_BOXES) : 1;
	localparam int SLOT_W = $clog2(MAX_MESSAGES) > 0 ? $clog2(MAX_MESSAGES) : 1;
	localparam int LEN_W  = $clog2(MAX_MESSAGES + 1);
	localparam int PAY_W  = 8 * PAYLOAD_BYTES;

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_ADD     = 2'd2;
	localparam logic [1:0] CMD_GET     = 2'd3;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_NOT_PERMITTED = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND     = 3'd2;
	localparam logic [2:0] ST_NO_SPACE      = 3'd3;
	localparam logic [2:0] ST_EMPTY_MESSAGE = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_BSCAN, S_DISPATCH, S_WALK_RD, S_WALK_CMP, S_GET_RD, S_GET_WB, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input beat
		logic bscan_clr;  // start box scan
		logic bscan_step; // examine one box
		logic walk_init;  // start queue walk at head
		logic walk_rd;    // issue slot read
		logic walk_next;  // follow successor
		logic get_rd;     // read head slot of best box
		logic commit;     // apply update, latch result
		logic out_take;   // result beat consumed
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       bscan_last;
		logic [1:0] cmd;
		logic       early;      // result known without scan
		logic       walk_done;  // walked whole queue
		logic       walk_hit;   // id match at current slot
		logic       no_msg;     // get finds nothing
		logic       out_valid;
	} stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/pmqm_ram.sv @@
// Generic simple dual-port RAM (separate write and read addresses), registered read.
// No dependencies.
`default_nettype none
module pmqm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/pmqm_ctrl.sv @@
// Controller state machine of the mailbox manager.
// Depends on pmqm_pkg.
`default_nettype none
module pmqm_ctrl import pmqm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire logic  out_stall,
	input  wire stat_t st,
	output cmd_t       cm
);
	state_t state_q, state_d;
	logic   out_busy;

	// result register still holds a beat that is not taken this cycle
	assign out_busy = st.out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands; hold any commit while the result register is busy
	always_comb begin
		state_d = state_q;
		cm = '0;
		in_stall = 1'b1;
		cm.out_take = st.out_valid && !out_stall;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cm.load = 1'b1;
					state_d = S_BSCAN;
				end
			end
			S_BSCAN: begin
				if (st.early) begin
					if (!out_busy) begin
						cm.commit = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cm.bscan_clr = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cm.bscan_step = 1'b1;
				if (st.bscan_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (st.cmd == CMD_ADD) begin
					cm.walk_init = 1'b1;
					state_d = S_WALK_RD;
				end else if (st.cmd == CMD_GET && !st.no_msg) begin
					cm.get_rd = 1'b1;
					state_d = S_GET_RD;
				end else if (!out_busy) begin
					cm.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK_RD: begin
				if (st.walk_done) begin
					if (!out_busy) begin
						cm.commit = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cm.walk_rd = 1'b1;
					state_d = S_WALK_CMP;
				end
			end
			S_WALK_CMP: begin
				if (st.walk_hit) begin
					if (!out_busy) begin
						cm.commit = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cm.walk_next = 1'b1;
					state_d = S_WALK_RD;
				end
			end
			// keep the head slot address on the RAMs until the commit
			S_GET_RD: begin
				cm.get_rd = 1'b1;
				state_d = S_GET_WB;
			end
			S_GET_WB: begin
				cm.get_rd = 1'b1;
				if (!out_busy) begin
					cm.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		cm.load |=> !cm.load) else $error("back-to-back load");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accept while busy");
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cm.commit |=> state_q == S_IDLE) else $error("commit not to idle");
endmodule
`default_nettype wire

@@ hw/rtl/pmqm_dp.sv @@
// Datapath: box table, slot store, scan and walk registers, result register.
// Depends on pmqm_pkg and pmqm_ram.
`default_nettype none
module pmqm_dp import pmqm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cm,
	output stat_t                   st,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [15:0] box_id,
	input  wire logic signed [31:0] msg_id,
	input  wire logic [63:0]        msg_payload_in,
	output logic [2:0]              status,
	output logic signed [31:0]      msg_id_out,
	output logic [63:0]             msg_payload_out,
	output logic                    out_valid
);
	// captured beat
	logic [1:0]       cmd_q;
	logic [15:0]      id_q;
	logic [31:0]      mid_q;
	logic [PAY_W-1:0] pay_q;

	// box table in flops
	logic [MAX_BOXES-1:0] in_use_q;
	logic [15:0]          ident_q [MAX_BOXES];
	logic [SLOT_W-1:0]    first_q [MAX_BOXES];
	logic [SLOT_W-1:0]    last_q  [MAX_BOXES];
	logic [LEN_W-1:0]     len_q   [MAX_BOXES];
	logic [MAX_MESSAGES-1:0] free_q;

	// scan registers
	logic [BOX_W-1:0] bidx_q;
	logic             found_q, freeb_ok_q, best_ok_q;
	logic [BOX_W-1:0] found_b_q, freeb_q, best_q;
	logic [LEN_W-1:0] wcnt_q;
	logic [SLOT_W-1:0] wslot_q;

	// slot store rams
	logic              ram_we;
	logic [SLOT_W-1:0] ram_wa, ram_ra, succ_wa;
	logic              succ_we;
	logic [SLOT_W-1:0] succ_wd, succ_rd;
	logic [31:0]       mid_rd;
	logic [PAY_W-1:0]  pay_rd;

	// lowest free slot, priority pick
	logic              slot_ok;
	logic [SLOT_W-1:0] slot_pick;
	always_comb begin
		slot_ok = 1'b0;
		slot_pick = '0;
		for (int i = MAX_MESSAGES - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				slot_ok = 1'b1;
				slot_pick = SLOT_W'(i);
			end
		end
	end

	logic early;
	always_comb begin
		case (cmd_q)
			CMD_ADD: early = id_q[15] || (pay_q[7:0] == 8'd0);
			CMD_GET: early = 1'b0;
			default: early = id_q[15];
		endcase
	end

	logic [2:0] early_st;
	always_comb begin
		case (cmd_q)
			CMD_CREATE: early_st = ST_NOT_PERMITTED;
			CMD_ADD:    early_st = id_q[15] ? ST_NOT_FOUND : ST_EMPTY_MESSAGE;
			default:    early_st = ST_NOT_FOUND;
		endcase
	end

	logic walk_hit;
	assign walk_hit = (mid_rd == mid_q);

	assign st.bscan_last = (bidx_q == BOX_W'(MAX_BOXES - 1));
	assign st.cmd        = cmd_q;
	assign st.early      = early;
	assign st.walk_done  = !found_q || (wcnt_q == len_q[found_b_q]);
	assign st.walk_hit   = walk_hit;
	assign st.no_msg     = !best_ok_q;
	assign st.out_valid  = out_valid;

	// final status for scanned commands
	logic [2:0] fin_st;
	always_comb begin
		case (cmd_q)
			CMD_CREATE: fin_st = found_q ? ST_NOT_PERMITTED
				: (freeb_ok_q ? ST_OK : ST_NO_SPACE);
			CMD_DESTROY: fin_st = !found_q ? ST_NOT_FOUND
				: (len_q[found_b_q] != '0 ? ST_NOT_PERMITTED : ST_OK);
			CMD_ADD: fin_st = !found_q ? ST_NOT_FOUND
				: (!st.walk_done ? ST_NOT_PERMITTED
				: (slot_ok ? ST_OK : ST_NO_SPACE));
			default: fin_st = best_ok_q ? ST_OK : ST_NOT_FOUND;
		endcase
	end

	logic add_ok, get_ok;
	assign add_ok = cm.commit && !early && cmd_q == CMD_ADD && fin_st == ST_OK;
	assign get_ok = cm.commit && cmd_q == CMD_GET && best_ok_q;

	assign ram_we = add_ok;
	assign ram_wa = slot_pick;
	assign ram_ra = cm.get_rd ? first_q[best_q] : (cm.walk_init ? first_q[found_b_q] : wslot_q);
	assign succ_we = add_ok;
	assign succ_wa = (len_q[found_b_q] != '0) ? last_q[found_b_q] : slot_pick;
	assign succ_wd = slot_pick;

	pmqm_ram #(.WIDTH(32), .DEPTH(MAX_MESSAGES)) u_mid (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(mid_q), .raddr(ram_ra), .rdata(mid_rd));
	pmqm_ram #(.WIDTH(PAY_W), .DEPTH(MAX_MESSAGES)) u_pay (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(pay_q), .raddr(ram_ra), .rdata(pay_rd));
	pmqm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_MESSAGES)) u_succ (
		.clk(clk), .we(succ_we), .waddr(succ_wa), .wdata(succ_wd), .raddr(ram_ra),
		.rdata(succ_rd));

	// capture beat
	always_ff @(posedge clk) begin
		if (cm.load) begin
			cmd_q <= cmd;
			id_q  <= box_id;
			mid_q <= msg_id;
			pay_q <= msg_payload_in[PAY_W-1:0];
		end
	end

	// scan and walk registers
	always_ff @(posedge clk) begin
		if (cm.bscan_clr) begin
			bidx_q <= '0;
			found_q <= 1'b0;
			freeb_ok_q <= 1'b0;
			best_ok_q <= 1'b0;
		end else if (cm.bscan_step) begin
			bidx_q <= bidx_q + 1'b1;
			if (in_use_q[bidx_q] && ident_q[bidx_q] == id_q) begin
				found_q <= 1'b1;
				found_b_q <= bidx_q;
			end
			if (!in_use_q[bidx_q] && !freeb_ok_q) begin
				freeb_ok_q <= 1'b1;
				freeb_q <= bidx_q;
			end
			if (in_use_q[bidx_q] && len_q[bidx_q] != '0 &&
				(!best_ok_q || ident_q[bidx_q] < ident_q[best_q])) begin
				best_ok_q <= 1'b1;
				best_q <= bidx_q;
			end
		end
		if (cm.walk_init) wcnt_q <= '0;
		else if (cm.walk_next) begin
			wcnt_q <= wcnt_q + 1'b1;
			wslot_q <= succ_rd;
		end
		if (cm.walk_init) wslot_q <= first_q[found_b_q];
	end

	// table update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			free_q <= '1;
			for (int b = 0; b < MAX_BOXES; b++) len_q[b] <= '0;
		end else if (cm.commit && !early) begin
			if (cmd_q == CMD_CREATE && fin_st == ST_OK) begin
				in_use_q[freeb_q] <= 1'b1;
				len_q[freeb_q] <= '0;
			end
			if (cmd_q == CMD_DESTROY && fin_st == ST_OK) in_use_q[found_b_q] <= 1'b0;
			if (add_ok) begin
				free_q[slot_pick] <= 1'b0;
				len_q[found_b_q] <= len_q[found_b_q] + 1'b1;
			end
			if (get_ok) begin
				free_q[first_q[best_q]] <= 1'b1;
				len_q[best_q] <= len_q[best_q] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cm.commit && !early) begin
			if (cmd_q == CMD_CREATE && fin_st == ST_OK) ident_q[freeb_q] <= id_q;
			if (add_ok) begin
				if (len_q[found_b_q] == '0) first_q[found_b_q] <= slot_pick;
				last_q[found_b_q] <= slot_pick;
			end
			if (get_ok) first_q[best_q] <= succ_rd;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cm.commit) out_valid <= 1'b1;
		else if (cm.out_take) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cm.commit) begin
			status <= early ? early_st : fin_st;
			msg_id_out <= get_ok ? mid_rd : '0;
			msg_payload_out <= get_ok ? 64'(pay_rd) : '0;
		end
	end

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cm.out_take |=> out_valid) else $error("result dropped");
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cm.commit |-> !out_valid || cm.out_take) else $error("result overwritten");
	a_add_slot: assert property (@(posedge clk) disable iff (!arst_n)
		add_ok |-> free_q[slot_pick]) else $error("slot reused");
endmodule
`default_nettype wire

@@ hw/rtl/priority_mailbox_queue_manager_top.sv @@
// Priority mailbox queue manager: one result beat per command beat.
// A beat rejected on its id or payload alone commits without a scan; create, destroy, get
// and add first scan the 16-box table, one box a cycle; add then walks the found box's queue,
// one slot RAM read per message walked, and a get with a message reads the head slot first.
// One command in flight; a waiting result beat holds the commit.
// Reset: arst_n async low clears box use, lengths and slot-free flags; no clearing pass.
`default_nettype none
module priority_mailbox_queue_manager_top import pmqm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [15:0] box_id,
	input  wire logic signed [31:0] msg_id,
	input  wire logic [63:0]        msg_payload_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic signed [31:0]      msg_id_out,
	output logic [63:0]             msg_payload_out
);
	cmd_t  cm;
	stat_t st;

	pmqm_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .st(st), .cm(cm));
	pmqm_dp u_dp (.clk(clk), .arst_n(arst_n), .cm(cm), .st(st), .cmd(cmd), .box_id(box_id),
		.msg_id(msg_id), .msg_payload_in(msg_payload_in), .status(status),
		.msg_id_out(msg_id_out), .msg_payload_out(msg_payload_out), .out_valid(out_valid));
endmodule
`default_nettype wire
